[hdl/ipr_pkg.sv]
// shared types, codes and constants of the in-place row permutation block
package ipr_pkg;

  localparam int DEF_MAX_ROWS = 1024;
  localparam int DEF_MAX_COLS = 8;

  localparam int REQ_W  = 2;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 3;
  localparam int PERM_W = 10;
  localparam int VAL_W  = 64;
  localparam int ELEM_W = 2 * VAL_W;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int ROWS_W    = 11;
  localparam int COLS_W    = 4;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd1024;
  localparam logic [COLS_W-1:0] COLS_RESET = 4'd1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_PERM = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_ELEM = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN       = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ      = 2'd3;

  // result kinds
  localparam logic KIND_RUN_DONE = 1'b0;
  localparam logic KIND_READ     = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  col_index;
    logic [PERM_W-1:0] perm_target;
    logic              direction;
    logic [VAL_W-1:0]  value_real;
    logic [VAL_W-1:0]  value_imag;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [VAL_W-1:0] read_real;
    logic [VAL_W-1:0] read_imag;
  } out_item_t;

  typedef struct packed {
    logic go;
    logic backward;
  } run_ctl_t;

  typedef struct packed {
    logic active;
    logic done;
  } run_stat_t;

endpackage

[hdl/ipr_ram.sv]
// generic simple dual-port ram with registered read
module ipr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/ipr_run_seq.sv]
// run sequencer: visited map, cycle walk and element-wise row swap
module ipr_run_seq #(
  parameter int MAX_ROWS = ipr_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ipr_pkg::DEF_MAX_COLS,
  localparam int RW  = $clog2(MAX_ROWS),
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int NW  = $clog2(MAX_ROWS + 1),
  localparam int CNW = $clog2(MAX_COLS + 1),
  localparam int MW  = RW + CW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ipr_pkg::run_ctl_t             ctl,
  input  logic [NW-1:0]                 nrows,
  input  logic [CNW-1:0]                ncols,
  output ipr_pkg::run_stat_t            stat,
  output logic [RW-1:0]                 perm_raddr,
  input  logic [ipr_pkg::PERM_W-1:0]    perm_rdata,
  output logic                          mat_we,
  output logic [MW-1:0]                 mat_waddr,
  output logic [ipr_pkg::ELEM_W-1:0]    mat_wdata,
  output logic [MW-1:0]                 mat_raddr,
  input  logic [ipr_pkg::ELEM_W-1:0]    mat_rdata
);
  import ipr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_KRD, S_KCHK, S_JRD, S_JCHK, S_RA, S_RB, S_WA, S_WB
  } state_t;

  state_t              state_r;
  logic [NW-1:0]       k_r;
  logic [RW-1:0]       j_r;
  logic [RW-1:0]       a_r;
  logic [RW-1:0]       b_r;
  logic [CNW-1:0]      c_r;
  logic [RW-1:0]       clr_r;
  logic                bwd_r;
  logic                done_r;
  logic [ELEM_W-1:0]   tmp_r;

  logic [RW-1:0]       k_idx;
  logic [CW-1:0]       c_idx;
  logic [RW-1:0]       k_tgt;
  logic [RW-1:0]       j_tgt;

  logic                vis_we;
  logic [RW-1:0]       vis_waddr;
  logic                vis_wdata;
  logic [RW-1:0]       vis_raddr;
  logic                vis_rdata;

  // entries at or beyond the row count keep their own row
  function automatic logic [RW-1:0] target_of(logic [PERM_W-1:0] t, logic [RW-1:0] row,
                                               logic [NW-1:0] n);
    return (32'(t) < 32'(n)) ? RW'(t) : row;
  endfunction

  assign k_idx = k_r[RW-1:0];
  assign c_idx = c_r[CW-1:0];
  assign k_tgt = target_of(perm_rdata, k_idx, nrows);
  assign j_tgt = target_of(perm_rdata, j_r, nrows);

  ipr_ram #(.WIDTH(1), .DEPTH(MAX_ROWS)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  always_comb begin
    perm_raddr = j_r;
    vis_raddr  = j_r;
    vis_we     = 1'b0;
    vis_waddr  = j_r;
    vis_wdata  = 1'b1;
    mat_we     = 1'b0;
    mat_waddr  = {a_r, c_idx};
    mat_wdata  = mat_rdata;
    mat_raddr  = {a_r, c_idx};
    case (state_r)
      S_CLR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_r;
        vis_wdata = 1'b0;
      end
      S_KRD: begin
        perm_raddr = k_idx;
        vis_raddr  = k_idx;
      end
      S_KCHK: begin
        vis_we    = !vis_rdata;
        vis_waddr = k_idx;
      end
      S_JCHK: begin
        vis_we    = !vis_rdata;
        vis_waddr = j_r;
      end
      S_RB: begin
        mat_raddr = {b_r, c_idx};
      end
      S_WA: begin
        mat_we = 1'b1;
      end
      S_WB: begin
        mat_we    = 1'b1;
        mat_waddr = {b_r, c_idx};
        mat_wdata = tmp_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (ctl.go) begin
            bwd_r   <= ctl.backward;
            clr_r   <= '0;
            state_r <= S_CLR;
          end
        end
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == RW'(MAX_ROWS - 1)) begin
            k_r     <= '0;
            state_r <= S_KRD;
          end
        end
        S_KRD: begin
          if (k_r == nrows) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_KCHK;
          end
        end
        S_KCHK: begin
          if (vis_rdata) begin
            k_r     <= k_r + 1'b1;
            state_r <= S_KRD;
          end else begin
            j_r     <= k_tgt;
            state_r <= S_JRD;
          end
        end
        S_JRD: begin
          state_r <= S_JCHK;
        end
        S_JCHK: begin
          if (vis_rdata) begin
            k_r     <= k_r + 1'b1;
            state_r <= S_KRD;
          end else begin
            // backward swaps with the cycle leader, forward with the next row
            a_r     <= j_r;
            b_r     <= bwd_r ? k_idx : j_tgt;
            j_r     <= j_tgt;
            c_r     <= '0;
            state_r <= (ncols == '0) ? S_JRD : S_RA;
          end
        end
        S_RA: begin
          state_r <= S_RB;
        end
        S_RB: begin
          tmp_r   <= mat_rdata;
          state_r <= S_WA;
        end
        S_WA: begin
          state_r <= S_WB;
        end
        S_WB: begin
          if ((c_r + 1'b1) == ncols) begin
            state_r <= S_JRD;
          end else begin
            c_r     <= c_r + 1'b1;
            state_r <= S_RA;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.active = (state_r != S_IDLE);
  assign stat.done   = done_r;

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RA || state_r == S_RB || state_r == S_WA || state_r == S_WB)
      |-> (c_r < ncols))
    else $error("swap column beyond columns in use");
  a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == S_KRD && state_r == S_IDLE))
    else $error("run done without finishing the row scan");
`endif

endmodule

[hdl/inplace_row_permute.sv]
// top level: request decode, configuration, memories and result register
//
// usage
// - input channel: a request (in_payload) transfers at a rising edge with start high
//   and busy low; request kinds are table load, element load, run and element read
// - table and element loads write memory at the transfer edge and leave busy low,
//   so a new request can follow in the very next cycle
// - an element read raises busy for one cycle; its result strobe (out_valid) is registered
//   from the registered matrix read data in the read state
// - a run raises busy for its whole length: visited-map clearing over all MAX_ROWS rows,
//   then the row scan, the cycle steps and the element-wise row swaps; the one read port
//   of the data memory paces the swaps
// - every result sits on out_payload for exactly one cycle with out_valid high; the
//   receiver takes it then, there is no stall
// - configuration: cfg_we writes cfg_data into register cfg_index (row count, column
//   count) at the edge; write it only while busy is low and no result is pending
// - reset (rst_n low at an edge) sets row count 1024, column count 1 and returns to
//   idle; table and matrix contents are undefined until loaded
module inplace_row_permute #(
  parameter int MAX_ROWS = ipr_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ipr_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  ipr_pkg::in_item_t                 in_payload,
  output logic                              out_valid,
  output ipr_pkg::out_item_t                out_payload,
  input  logic                              cfg_we,
  input  logic [ipr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipr_pkg::CFG_W-1:0]         cfg_data
);
  import ipr_pkg::*;

  localparam int RW        = $clog2(MAX_ROWS);
  localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NW        = $clog2(MAX_ROWS + 1);
  localparam int CNW       = $clog2(MAX_COLS + 1);
  localparam int MW        = RW + CW;
  localparam int MAT_DEPTH = MAX_ROWS * (2 ** CW);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_RD} state_t;

  state_t             state_r;
  logic [ROWS_W-1:0]  rows_r;
  logic [COLS_W-1:0]  cols_r;
  logic               out_valid_r;
  out_item_t          out_item_r;
  logic               rd_ok_r;

  logic               accept;
  logic               row_ok;
  logic               elem_ok;
  logic [RW-1:0]      host_row;
  logic [MW-1:0]      host_addr;
  logic [NW-1:0]      nrows;
  logic [CNW-1:0]     ncols;
  logic               in_run;

  run_ctl_t           seq_ctl;
  run_stat_t          seq_stat;
  logic [RW-1:0]      seq_perm_raddr;
  logic [PERM_W-1:0]  perm_rdata;
  logic               perm_we;
  logic               seq_mat_we;
  logic [MW-1:0]      seq_mat_waddr;
  logic [ELEM_W-1:0]  seq_mat_wdata;
  logic [MW-1:0]      seq_mat_raddr;
  logic               mat_we;
  logic [MW-1:0]      mat_waddr;
  logic [ELEM_W-1:0]  mat_wdata;
  logic [MW-1:0]      mat_raddr;
  logic [ELEM_W-1:0]  mat_rdata;

  // request transfer
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign in_run = (state_r == ST_RUN);

  // loads and reads may reach any stored row, not only the ones in use
  assign row_ok    = 32'(in_payload.row_index) < MAX_ROWS;
  assign elem_ok   = row_ok && (32'(in_payload.col_index) < MAX_COLS);
  assign host_row  = RW'(in_payload.row_index);
  assign host_addr = {host_row, CW'(in_payload.col_index)};

  // register values above storage act as the storage size
  assign nrows = (32'(rows_r) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(rows_r);
  assign ncols = (32'(cols_r) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(cols_r);

  assign seq_ctl.go       = accept && (in_payload.req_type == REQ_RUN);
  assign seq_ctl.backward = in_payload.direction;

  // permutation table: host writes, sequencer reads
  assign perm_we = accept && (in_payload.req_type == REQ_LOAD_PERM) && row_ok;

  ipr_ram #(.WIDTH(PERM_W), .DEPTH(MAX_ROWS)) u_perm (
    .clk   (clk),
    .we    (perm_we),
    .waddr (host_row),
    .wdata (in_payload.perm_target),
    .raddr (seq_perm_raddr),
    .rdata (perm_rdata)
  );

  // matrix: the sequencer owns the ports during a run, the host otherwise
  always_comb begin
    if (in_run) begin
      mat_we    = seq_mat_we;
      mat_waddr = seq_mat_waddr;
      mat_wdata = seq_mat_wdata;
      mat_raddr = seq_mat_raddr;
    end else begin
      mat_we    = accept && (in_payload.req_type == REQ_LOAD_ELEM) && elem_ok;
      mat_waddr = host_addr;
      mat_wdata = {in_payload.value_real, in_payload.value_imag};
      mat_raddr = host_addr;
    end
  end

  ipr_ram #(.WIDTH(ELEM_W), .DEPTH(MAT_DEPTH)) u_matrix (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  ipr_run_seq #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (seq_ctl),
    .nrows      (nrows),
    .ncols      (ncols),
    .stat       (seq_stat),
    .perm_raddr (seq_perm_raddr),
    .perm_rdata (perm_rdata),
    .mat_we     (seq_mat_we),
    .mat_waddr  (seq_mat_waddr),
    .mat_wdata  (seq_mat_wdata),
    .mat_raddr  (seq_mat_raddr),
    .mat_rdata  (mat_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rows_r      <= ROWS_RESET;
      cols_r      <= COLS_RESET;
    end else begin
      out_valid_r <= 1'b0;

      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS: rows_r <= cfg_data[ROWS_W-1:0];
          CFG_COLS: cols_r <= cfg_data[COLS_W-1:0];
          default: begin
          end
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_payload.req_type)
              REQ_RUN: begin
                state_r <= ST_RUN;
              end
              REQ_READ: begin
                // read address went to the matrix at this edge
                rd_ok_r <= elem_ok;
                state_r <= ST_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (seq_stat.done) begin
            out_valid_r            <= 1'b1;
            out_item_r.result_kind <= KIND_RUN_DONE;
            out_item_r.read_real   <= '0;
            out_item_r.read_imag   <= '0;
            state_r                <= ST_IDLE;
          end
        end
        ST_RD: begin
          out_valid_r            <= 1'b1;
          out_item_r.result_kind <= KIND_READ;
          out_item_r.read_real   <= rd_ok_r ? mat_rdata[ELEM_W-1:VAL_W] : '0;
          out_item_r.read_imag   <= rd_ok_r ? mat_rdata[VAL_W-1:0] : '0;
          state_r                <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_item_r;

`ifndef SYNTHESIS
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    seq_stat.done |-> (state_r == ST_RUN))
    else $error("sequencer finished outside a run");
  a_seq_tracks_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && !seq_stat.done) |-> seq_stat.active)
    else $error("run pending but sequencer idle");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_RD || $past(state_r) == ST_RUN))
    else $error("result strobe without a read or run");
`endif

endmodule
